FILE: design/nps_pkg.sv
// nearest point store package: payload structs, command and status codes
// shared by the controller, datapath and top level; no dependencies
`default_nettype none
package nps_pkg;
    localparam int MaxPoints = 256;
    localparam int IdxBits   = $clog2(MaxPoints);
    localparam int CntBits   = $clog2(MaxPoints + 1);
    localparam int SqBits    = 21;
    localparam int RootBits  = 11;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_PARENT = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] px;
        logic [9:0] py;
        logic [7:0] parent_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_index;
        logic [9:0]  found_x;
        logic [9:0]  found_y;
        logic [10:0] distance;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic clear;     // set root
        logic insert;    // append point
        logic scan_rd;   // issue read of scan index
        logic [IdxBits-1:0] rd_idx;
        logic dist_go;   // start root on read data
        logic cmp;       // compare finished distance
        logic first;     // first compared entry
        logic fetch;     // read best entry
    } t_cmd;

    typedef struct packed {
        logic [CntBits-1:0] count;
        logic dist_done;
    } t_stat;
endpackage
`default_nettype wire

FILE: design/nps_ctrl.sv
// nearest point store controller: request sequencing and the scan loop
// depends on nps_pkg
`default_nettype none
module nps_ctrl
    import nps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_parent_index,
    input  wire logic i_out_stall,
    input  wire t_stat i_stat,
    output logic o_in_stall,
    output logic o_out_valid,
    output logic o_ready_res,
    output logic [1:0] o_status,
    output logic o_use_best,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_ROOT = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] r_state, n_state;
    logic [CntBits-1:0] r_idx, n_idx;
    logic r_first, n_first;
    logic [1:0] r_status, n_status;
    logic r_use_best, n_use_best;
    logic accept, ins_ok;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_ready_res = o_out_valid;
    assign o_status    = r_status;
    assign o_use_best  = r_use_best;
    assign accept = i_in_valid && (r_state == S_IDLE);
    assign ins_ok = (i_stat.count != '0) && (i_stat.count < CntBits'(MaxPoints))
                    && ({1'b0, i_parent_index} < 9'(i_stat.count));

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_first = r_first;
        n_status = r_status;
        n_use_best = r_use_best;
        o_cmd = '0;
        o_cmd.rd_idx = r_idx[IdxBits-1:0];
        o_cmd.first = r_first;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_status = ST_OK;
                    n_use_best = 1'b0;
                    n_state = S_OUT;
                    unique case (i_cmd)
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        CMD_QUERY: begin
                            if (i_stat.count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx = '0;
                                n_first = 1'b1;
                                n_use_best = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        CMD_INSERT: begin
                            if (i_stat.count == '0) n_status = ST_EMPTY;
                            else if (i_stat.count >= CntBits'(MaxPoints)) n_status = ST_FULL;
                            else if (!ins_ok) n_status = ST_PARENT;
                            else o_cmd.insert = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.dist_go = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.dist_done) begin
                    o_cmd.cmp = 1'b1;
                    n_first = 1'b0;
                    n_idx = r_idx + 1'b1;
                    if (r_idx + 1'b1 >= i_stat.count) n_state = S_FETCH;
                    else n_state = S_READ;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_first <= 1'b0;
            r_status <= ST_OK;
            r_use_best <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_first <= n_first;
            r_status <= n_status;
            r_use_best <= n_use_best;
        end
    end
endmodule
`default_nettype wire

FILE: design/nps_dp.sv
// nearest point store datapath: point memories, distance, serial root, best register
// depends on nps_pkg
`default_nettype none
module nps_dp
    import nps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in i_req,
    input  wire t_cmd i_cmd,
    input  wire logic i_use_best,
    input  wire logic [1:0] i_status,
    output t_stat o_stat,
    output t_out o_res
);
    logic [9:0] mem_x [MaxPoints];
    logic [9:0] mem_y [MaxPoints];
    logic [7:0] mem_p [MaxPoints];
    logic [CntBits-1:0] r_count;
    t_in r_req;
    logic [9:0] r_rx, r_ry;
    logic [IdxBits-1:0] r_best, r_cur;
    logic [10:0] r_best_d;
    logic [9:0] r_fx, r_fy;
    logic [7:0] r_par;
    logic [IdxBits-1:0] r_new;
    // root unit
    logic [SqBits-1:0] r_rem;
    logic [RootBits-1:0] r_root;
    logic [3:0] r_step;
    logic r_busy, r_done;
    logic [9:0] dx, dy;
    logic [19:0] sx, sy;
    logic [SqBits-1:0] sq;
    logic [RootBits+1:0] trial;
    logic [SqBits-1:0] top;

    assign dx = (r_rx > r_req.px) ? r_rx - r_req.px : r_req.px - r_rx;
    assign dy = (r_ry > r_req.py) ? r_ry - r_req.py : r_req.py - r_ry;
    assign sx = dx * dx;
    assign sy = dy * dy;
    assign sq = SqBits'(sx) + SqBits'(sy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_x[0] <= i_req.px;
            mem_y[0] <= i_req.py;
            mem_p[0] <= '0;
        end else if (i_cmd.insert) begin
            mem_x[r_count[IdxBits-1:0]] <= i_req.px;
            mem_y[r_count[IdxBits-1:0]] <= i_req.py;
            mem_p[r_count[IdxBits-1:0]] <= i_req.parent_index;
        end
        if (i_cmd.scan_rd || i_cmd.fetch) begin
            r_rx <= mem_x[i_cmd.scan_rd ? i_cmd.rd_idx : r_best];
            r_ry <= mem_y[i_cmd.scan_rd ? i_cmd.rd_idx : r_best];
        end
        if (i_cmd.scan_rd) r_cur <= i_cmd.rd_idx;
        if (i_cmd.load) begin
            r_req <= i_req;
            r_new <= r_count[IdxBits-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= CntBits'(1);
        end else if (i_cmd.insert) begin
            r_count <= r_count + 1'b1;
        end
    end

    // bit-serial square root, two remainder bits a step
    assign top = SqBits'(r_rem >> (2 * r_step));
    assign trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.dist_go) begin
                r_busy <= 1'b1;
                r_step <= 4'd10;
                r_rem <= sq;
                r_root <= '0;
            end else if (r_busy) begin
                if (SqBits'(top) >= SqBits'(trial)) begin
                    r_rem <= r_rem - (SqBits'(trial) << (2 * r_step));
                    r_root <= {r_root[RootBits-2:0], 1'b1};
                end else begin
                    r_root <= {r_root[RootBits-2:0], 1'b0};
                end
                if (r_step == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp && (i_cmd.first || r_root < r_best_d)) begin
            r_best <= r_cur;
            r_best_d <= r_root;
        end
        if (i_cmd.fetch || i_cmd.load) begin
            r_fx <= i_cmd.load ? i_req.px : mem_x[r_best];
            r_fy <= i_cmd.load ? i_req.py : mem_y[r_best];
        end
        if (i_cmd.fetch) r_par <= mem_p[r_best];
    end

    assign o_stat.count = r_count;
    assign o_stat.dist_done = r_done;

    always_comb begin
        o_res = '0;
        o_res.status = i_status;
        if (i_use_best) begin
            o_res.entry_index = 8'(r_best);
            o_res.found_x = r_fx;
            o_res.found_y = r_fy;
            o_res.distance = r_best_d;
        end else if (i_status == ST_OK && r_req.cmd == CMD_INSERT) begin
            o_res.entry_index = 8'(r_new);
            o_res.found_x = r_fx;
            o_res.found_y = r_fy;
        end else if (i_status == ST_OK && r_req.cmd == CMD_CLEAR) begin
            o_res.found_x = r_fx;
            o_res.found_y = r_fy;
        end
    end

    logic unused_p;
    assign unused_p = ^r_par;
endmodule
`default_nettype wire

FILE: design/nearest_point_store.sv
// nearest point store top level: joins controller and datapath
// depends on nps_pkg, nps_ctrl, nps_dp
`default_nettype none
// One request at a time; the input stays stalled until the result has been taken.
// Clear, insert, unused commands and queries on an empty store offer their result in the cycle after acceptance.
// A query scans every stored entry in order, each passing through a read state, a start
// state, the eleven-step bit-serial square root and a compare; a fetch state then reads
// the best entry before the result is offered. Ties keep the earlier entry. Points never
// written are never read.
module nearest_point_store
    import nps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic o_in_stall,
    input  wire t_in i_in_data,
    output logic o_out_valid,
    input  wire logic i_out_stall,
    output t_out o_out_data
);
    t_cmd cmd;
    t_stat stat;
    logic [1:0] status;
    logic use_best, res_v;

    nps_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_cmd(i_in_data.cmd), .i_parent_index(i_in_data.parent_index),
        .i_out_stall, .i_stat(stat), .o_in_stall, .o_out_valid,
        .o_ready_res(res_v), .o_status(status), .o_use_best(use_best), .o_cmd(cmd)
    );

    nps_dp u_dp (
        .i_clk, .i_rst_n, .i_req(i_in_data), .i_cmd(cmd), .i_use_best(use_best),
        .i_status(status), .o_stat(stat), .o_res(o_out_data)
    );

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= CntBits'(MaxPoints)) else $error("count overflow");
    a_nostall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_v |-> o_in_stall) else $error("input open with result pending");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |=> stat.count == CntBits'(1)) else $error("clear count");
endmodule
`default_nettype wire

FILE: tb/tb_nearest_point_store.sv
// testbench for nearest_point_store: clear, query, insert and unused-command requests checked
// against an in-bench point store model; depends on nps_pkg and the design files
`timescale 1ns / 1ps
module tb_nearest_point_store;
    import nps_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    nearest_point_store i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // in-bench copy of the store
    logic [9:0] pts_x [MaxPoints];
    logic [9:0] pts_y [MaxPoints];
    int         pts_n;

    t_in  pending_reqs[$];
    t_out expected_res[$];
    int   mismatches;
    int   n_results;
    int   n_queries;
    int   n_full;
    bit   hold_out;
    bit   flush_pause;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [10:0] int_root(input logic [20:0] v);
        logic [10:0] r;
        r = '0;
        for (int b = 10; b >= 0; b--) begin
            logic [10:0] t;
            t = r | (11'd1 << b);
            if ({11'd0, t} * {11'd0, t} <= {1'b0, v}) r = t;
        end
        return r;
    endfunction

    function automatic t_out nearest_result(input t_in rq);
        t_out o;
        logic [10:0] d, best_d;
        logic [9:0] dx, dy;
        int best;
        o = '0;
        case (rq.cmd)
            CMD_CLEAR: begin
                pts_x[0] = rq.px;
                pts_y[0] = rq.py;
                pts_n = 1;
                o.found_x = rq.px;
                o.found_y = rq.py;
            end
            CMD_QUERY: begin
                if (pts_n == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    best = 0;
                    best_d = '1;
                    for (int i = 0; i < pts_n; i++) begin
                        dx = pts_x[i] > rq.px ? pts_x[i] - rq.px : rq.px - pts_x[i];
                        dy = pts_y[i] > rq.py ? pts_y[i] - rq.py : rq.py - pts_y[i];
                        d = int_root(21'(dx) * 21'(dx) + 21'(dy) * 21'(dy));
                        if (i == 0 || d < best_d) begin
                            best_d = d;
                            best = i;
                        end
                    end
                    o.entry_index = 8'(best);
                    o.found_x = pts_x[best];
                    o.found_y = pts_y[best];
                    o.distance = best_d;
                end
            end
            CMD_INSERT: begin
                if (pts_n == 0) o.status = ST_EMPTY;
                else if (pts_n >= MaxPoints) o.status = ST_FULL;
                else if (rq.parent_index >= pts_n) o.status = ST_PARENT;
                else begin
                    pts_x[pts_n] = rq.px;
                    pts_y[pts_n] = rq.py;
                    o.entry_index = 8'(pts_n);
                    o.found_x = rq.px;
                    o.found_y = rq.py;
                    pts_n++;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report(input string what, input logic [10:0] got, input logic [10:0] exp);
        $display("mismatch at result %0d: %s got %0d want %0d", n_results, what, got, exp);
        mismatches++;
    endtask

    function automatic t_in mk(input logic [1:0] c, input int x, input int y, input int p);
        t_in r;
        r.cmd = c;
        r.px = 10'(x);
        r.py = 10'(y);
        r.parent_index = 8'(p);
        return r;
    endfunction

    // driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            in_gap     <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // hold the offered request
        end else begin
            if (i_in_valid) begin
                if (i_in_data.cmd == CMD_QUERY) n_queries++;
                expected_res.push_back(nearest_result(i_in_data));
            end
            if (in_gap > 0 || flush_pause || pending_reqs.size() == 0) begin
                i_in_valid <= 1'b0;
                if (in_gap > 0) in_gap <= in_gap - 1;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_reqs.pop_front();
                in_gap     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    // monitor and result-side stall
    int out_gap;
    always @(posedge i_clk) begin
        t_out e;
        int g;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap     <= 0;
        end else begin
            g = out_gap;
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (o_out_data.status == ST_FULL) n_full++;
                if (expected_res.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    mismatches++;
                end else begin
                    e = expected_res.pop_front();
                    if (o_out_data.status != e.status)
                        report("status", o_out_data.status, e.status);
                    if (o_out_data.entry_index != e.entry_index)
                        report("entry_index", o_out_data.entry_index, e.entry_index);
                    if (o_out_data.found_x != e.found_x)
                        report("found_x", o_out_data.found_x, e.found_x);
                    if (o_out_data.found_y != e.found_y)
                        report("found_y", o_out_data.found_y, e.found_y);
                    if (o_out_data.distance != e.distance)
                        report("distance", o_out_data.distance, e.distance);
                end
                g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (hold_out) begin
                i_out_stall <= 1'b1;
            end else if (g > 0) begin
                i_out_stall <= 1'b1;
                g = g - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
            out_gap <= g;
        end
    end

    // random coordinate, mostly small clusters with full-range outliers
    function automatic int rc();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_in_valid || expected_res.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n, hold_cnt;
        bit paused;
        mismatches = 0;
        n_results = 0;
        n_queries = 0;
        n_full = 0;
        pts_n = 0;
        paused = 1'b0;
        hold_out = 1'b0;
        flush_pause = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, clear, extremes, bad parent, tie, unused command
        pending_reqs.push_back(mk(CMD_QUERY, 5, 5, 0));
        pending_reqs.push_back(mk(CMD_INSERT, 5, 5, 0));
        pending_reqs.push_back(mk(2'd3, 1023, 1023, 255));
        pending_reqs.push_back(mk(CMD_CLEAR, 1023, 1023, 255));
        pending_reqs.push_back(mk(CMD_QUERY, 0, 0, 0));
        pending_reqs.push_back(mk(CMD_INSERT, 0, 0, 0));
        pending_reqs.push_back(mk(CMD_INSERT, 0, 0, 255));
        pending_reqs.push_back(mk(CMD_INSERT, 2, 0, 2));
        pending_reqs.push_back(mk(CMD_INSERT, 0, 2, 1));
        pending_reqs.push_back(mk(CMD_INSERT, 1023, 0, 1));
        pending_reqs.push_back(mk(CMD_INSERT, 0, 1023, 3));
        pending_reqs.push_back(mk(CMD_QUERY, 1, 1, 0));
        pending_reqs.push_back(mk(CMD_QUERY, 1023, 1023, 255));
        pending_reqs.push_back(mk(CMD_QUERY, 700, 300, 0));
        pending_reqs.push_back(mk(2'd3, 0, 0, 0));
        pending_reqs.push_back(mk(CMD_QUERY, 0, 1023, 0));
        wait_drained();

        // long receiver hold while requests keep coming
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(mk(i % 3 == 0 ? CMD_QUERY : CMD_INSERT, rc(), rc(), 0));
        hold_out = 1'b1;
        hold_cnt = 0;
        while (hold_cnt < 400) begin
            @(posedge i_clk);
            hold_cnt++;
        end
        hold_out = 1'b0;
        wait_drained();

        // fill the store to capacity once, then hit the full case
        pending_reqs.push_back(mk(CMD_CLEAR, rc(), rc(), 0));
        for (int i = 1; i < MaxPoints + 3; i++)
            pending_reqs.push_back(mk(CMD_INSERT, $urandom_range(0, 1023),
                                      $urandom_range(0, 1023), $urandom_range(0, i - 1)));
        for (int i = 0; i < 4; i++)
            pending_reqs.push_back(mk(CMD_QUERY, $urandom_range(0, 1023),
                                      $urandom_range(0, 1023), 0));
        wait_drained();

        // random trees: small ones mostly, queries interleaved
        n = 0;
        while (n < 1610) begin
            int sz;
            sz = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
            pending_reqs.push_back(mk(CMD_CLEAR, rc(), rc(), $urandom_range(0, 255)));
            n++;
            for (int k = 0; k < sz; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: pending_reqs.push_back(mk(CMD_INSERT, rc(), rc(),
                                                          $urandom_range(0, k)));
                    4: pending_reqs.push_back(mk(CMD_INSERT, rc(), rc(),
                                                 $urandom_range(0, 255)));
                    5: pending_reqs.push_back(mk(2'd3, $urandom_range(0, 1023),
                                                 $urandom_range(0, 1023),
                                                 $urandom_range(0, 255)));
                    default: pending_reqs.push_back(mk(CMD_QUERY, rc(), rc(),
                                                       $urandom_range(0, 255)));
                endcase
                n++;
            end
            if (!paused && n > 700) begin
                // sender stands still with requests queued until all answers are in
                paused = 1'b1;
                flush_pause = 1'b1;
                while (i_in_valid || expected_res.size() != 0) @(posedge i_clk);
                flush_pause = 1'b0;
            end
        end
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d results, %0d queries, %0d store-full answers",
                 n_results, n_queries, n_full);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #200ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: filelist.f
design/nps_pkg.sv
design/nps_ctrl.sv
design/nps_dp.sv
design/nearest_point_store.sv
tb/tb_nearest_point_store.sv
